/* rtl/thc_pkg.sv */
package thc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  // Q16 unit, squared reference for the cosine root, heading full scale
  localparam logic [32:0] ONE_SQ    = 33'h1_0000_0000;
  localparam logic [17:0] ONE_Q16   = 18'd65536;
  localparam logic [14:0] HEAD_FULL = 15'd23040;
  localparam int          SQ_BITS   = 17;
  localparam int          CW        = 40;

  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;

  typedef struct packed {
    logic signed [17:0] sp;
    logic [16:0]        cp;
    logic signed [17:0] sr;
    logic signed [16:0] mx;
    logic signed [16:0] my;
    logic signed [16:0] mz;
    logic [17:0]        mag;
    logic               neg;
    logic               flag;
    logic               sat;
    logic               zr;
    logic               hz;
  } side_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/thc_sqrt_cell.sv */
module thc_sqrt_cell
  import thc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [4:0]  k,
  input  logic        vld_in,
  input  side_t       side_in,
  input  logic [32:0] v_in,
  input  logic [16:0] r_in,
  input  logic [33:0] r2_in,
  output logic        vld_r,
  output side_t       side_r,
  output logic [32:0] v_r,
  output logic [16:0] r_r,
  output logic [33:0] r2_r
);

  logic [35:0] cand;
  logic [16:0] r_nxt;
  logic [33:0] r2_nxt;

  // (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k), r holds only bits above k
  always_comb begin
    cand   = {2'b00, r2_in} + (36'(r_in) << (6'(k) + 6'd1)) + (36'd1 << {k, 1'b0});
    r_nxt  = r_in;
    r2_nxt = r2_in;
    if (cand <= {3'b000, v_in}) begin
      r_nxt  = r_in | (17'd1 << k);
      r2_nxt = cand[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      v_r    <= v_in;
      r_r    <= r_nxt;
      r2_r   <= r2_nxt;
    end
  end

endmodule

/* rtl/thc_div_cell.sv */
module thc_div_cell
  import thc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [4:0]  k,
  input  logic        vld_in,
  input  side_t       side_in,
  input  logic [34:0] rem_in,
  input  logic [16:0] q_in,
  output logic        vld_r,
  output side_t       side_r,
  output logic [34:0] rem_r,
  output logic [16:0] q_r
);

  logic [34:0] d;
  logic [34:0] rem_nxt;
  logic [16:0] q_nxt;

  always_comb begin
    d       = 35'(side_in.cp) << k;
    rem_nxt = rem_in;
    q_nxt   = q_in;
    if (rem_in >= d) begin
      rem_nxt = rem_in - d;
      q_nxt   = q_in | (17'd1 << k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

endmodule

/* rtl/thc_cordic_cell.sv */
module thc_cordic_cell
  import thc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [4:0]           i,
  input  logic                 vld_in,
  input  side_t                side_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [31:0]          z_in,
  output logic                 vld_r,
  output side_t                side_r,
  output logic signed [CW-1:0] x_r,
  output logic signed [CW-1:0] y_r,
  output logic [31:0]          z_r
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic [31:0]          z_nxt;

  // rotate toward y = 0, angle wraps mod one turn
  always_comb begin
    dx = y_in >>> i;
    dy = x_in >>> i;
    if (!y_in[CW-1]) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + atan_turn(i);
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - atan_turn(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

endmodule

/* rtl/tilt_compensated_heading.sv */
// Throughput: one word per cycle; the whole row of cells advances together and
// holds only while a finished result waits under out_stall.
// Reset (synchronous, rst_n low): all valid bits clear, offsets return to 0;
// datapath registers are not reset.
module tilt_compensated_heading
  import thc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  input  logic signed [15:0] in_mag_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_heading,
  output logic               out_tilt_clamped
);

  logic               en;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_X: off_x_r <= cfg_wdata;
        REG_OFF_Y: off_y_r <= cfg_wdata;
        REG_OFF_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: offsets, pitch sine
  logic signed [18:0] spr, ayq;
  side_t              s0_nxt, s0_r;
  logic               s0_v_r;

  always_comb begin
    s0_nxt      = '0;
    spr         = -(19'(in_accel_x) * 19'sd4);
    ayq         = 19'(in_accel_y) * 19'sd4;
    s0_nxt.mx   = 17'(in_mag_x) - 17'(off_x_r);
    s0_nxt.my   = 17'(in_mag_y) - 17'(off_y_r);
    s0_nxt.mz   = 17'(in_mag_z) - 17'(off_z_r);
    s0_nxt.neg  = ayq[18];
    s0_nxt.mag  = ayq[18] ? 18'(-ayq) : 18'(ayq);
    s0_nxt.sp   = spr[17:0];
    if (spr > 19'sd65536) begin
      s0_nxt.sp   = $signed(ONE_Q16);
      s0_nxt.flag = 1'b1;
    end else if (spr < -19'sd65536) begin
      s0_nxt.sp   = -$signed(ONE_Q16);
      s0_nxt.flag = 1'b1;
    end
  end

  // ---------------- stage 1: radicand for cos pitch
  logic signed [35:0] sq_p;
  side_t              s1_r;
  logic               s1_v_r;
  logic [32:0]        s1_rad_r;

  assign sq_p = s0_r.sp * s0_r.sp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r     <= s0_nxt;
      s1_r     <= s0_r;
      s1_rad_r <= ONE_SQ - sq_p[32:0];
    end
  end

  // ---------------- root chain for cos pitch
  logic        av  [0:SQ_BITS];
  side_t       as_ [0:SQ_BITS];
  logic [32:0] ara [0:SQ_BITS];
  logic [16:0] ar  [0:SQ_BITS];
  logic [33:0] ar2 [0:SQ_BITS];

  assign av[0]  = s1_v_r;
  assign as_[0] = s1_r;
  assign ara[0] = s1_rad_r;
  assign ar[0]  = '0;
  assign ar2[0] = '0;

  for (genvar g = 0; g < SQ_BITS; g++) begin : g_sqa
    thc_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .k(5'(SQ_BITS - 1 - g)),
      .vld_in(av[g]), .side_in(as_[g]), .v_in(ara[g]), .r_in(ar[g]), .r2_in(ar2[g]),
      .vld_r(av[g+1]), .side_r(as_[g+1]), .v_r(ara[g+1]), .r_r(ar[g+1]), .r2_r(ar2[g+1])
    );
  end

  // ---------------- stage 2: roll saturation check
  side_t       s2_nxt, s2_r;
  logic        s2_v_r;

  always_comb begin
    s2_nxt      = as_[SQ_BITS];
    s2_nxt.cp   = ar[SQ_BITS];
    s2_nxt.sat  = as_[SQ_BITS].mag > {1'b0, ar[SQ_BITS]};
    s2_nxt.zr   = ar[SQ_BITS] == '0;
    s2_nxt.flag = as_[SQ_BITS].flag | s2_nxt.sat;
  end

  // ---------------- divide chain for sin roll
  logic        dv  [0:SQ_BITS];
  side_t       ds  [0:SQ_BITS];
  logic [34:0] drem[0:SQ_BITS];
  logic [16:0] dq  [0:SQ_BITS];

  assign dv[0]   = s2_v_r;
  assign ds[0]   = s2_r;
  assign drem[0] = {1'b0, s2_r.mag, 16'd0};
  assign dq[0]   = '0;

  for (genvar g = 0; g < SQ_BITS; g++) begin : g_div
    thc_div_cell u_cell (
      .clk, .rst_n, .en,
      .k(5'(SQ_BITS - 1 - g)),
      .vld_in(dv[g]), .side_in(ds[g]), .rem_in(drem[g]), .q_in(dq[g]),
      .vld_r(dv[g+1]), .side_r(ds[g+1]), .rem_r(drem[g+1]), .q_r(dq[g+1])
    );
  end

  // ---------------- stage 3: signed sin roll, stage 4: radicand for cos roll
  side_t              s3_nxt, s3_r, s4_r;
  logic               s3_v_r, s4_v_r;
  logic [17:0]        srm;
  logic signed [35:0] sq_r;
  logic [32:0]        s4_rad_r;

  always_comb begin
    s3_nxt = ds[SQ_BITS];
    if (ds[SQ_BITS].sat) begin
      srm = ONE_Q16;
    end else if (ds[SQ_BITS].zr) begin
      srm = '0;
    end else begin
      srm = {1'b0, dq[SQ_BITS]};
    end
    s3_nxt.sr = ds[SQ_BITS].neg ? -$signed(srm) : $signed(srm);
  end

  assign sq_r = s3_r.sr * s3_r.sr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= av[SQ_BITS];
      s3_v_r <= dv[SQ_BITS];
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      s4_r     <= s3_r;
      s4_rad_r <= ONE_SQ - sq_r[32:0];
    end
  end

  // ---------------- root chain for cos roll
  logic        bv  [0:SQ_BITS];
  side_t       bs  [0:SQ_BITS];
  logic [32:0] bra [0:SQ_BITS];
  logic [16:0] br  [0:SQ_BITS];
  logic [33:0] br2 [0:SQ_BITS];

  assign bv[0]  = s4_v_r;
  assign bs[0]  = s4_r;
  assign bra[0] = s4_rad_r;
  assign br[0]  = '0;
  assign br2[0] = '0;

  for (genvar g = 0; g < SQ_BITS; g++) begin : g_sqb
    thc_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .k(5'(SQ_BITS - 1 - g)),
      .vld_in(bv[g]), .side_in(bs[g]), .v_in(bra[g]), .r_in(br[g]), .r2_in(br2[g]),
      .vld_r(bv[g+1]), .side_r(bs[g+1]), .v_r(bra[g+1]), .r_r(br[g+1]), .r2_r(br2[g+1])
    );
  end

  // ---------------- stages 5..8: rotate field into the horizontal plane
  side_t              s5_r, s6_r, s7_r, s8_r;
  side_t              s8_nxt;
  logic               s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic signed [17:0] cps, crs;
  logic signed [35:0] t_a, t_b;
  logic signed [17:0] s5_a_r, s5_b_r;
  logic signed [34:0] s5_p1_r, s5_p2_r, s5_p3_r;
  logic signed [34:0] s6_p1_r, s6_p2_r, s6_p3_r, s6_q1_r, s6_q2_r;
  logic signed [35:0] xh, yh;
  logic signed [35:0] s7_xh_r, s7_yh_r;
  logic signed [CW-1:0] s8_x_r, s8_y_r;
  logic [31:0]          s8_z_r;

  assign cps = $signed({1'b0, bs[SQ_BITS].cp});
  assign crs = $signed({1'b0, br[SQ_BITS]});
  assign t_a = bs[SQ_BITS].sr * bs[SQ_BITS].sp;
  assign t_b = bs[SQ_BITS].sr * cps;
  assign xh  = 36'(s6_p1_r) + 36'(s6_p2_r);
  assign yh  = 36'(s6_q1_r) + 36'(s6_p3_r) - 36'(s6_q2_r);

  always_comb begin
    s8_nxt    = s7_r;
    s8_nxt.hz = (s7_xh_r == '0) && (s7_yh_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= bv[SQ_BITS];
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r    <= bs[SQ_BITS];
      s5_a_r  <= t_a[33:16];
      s5_b_r  <= t_b[33:16];
      s5_p1_r <= bs[SQ_BITS].mx * cps;
      s5_p2_r <= bs[SQ_BITS].mz * bs[SQ_BITS].sp;
      s5_p3_r <= bs[SQ_BITS].my * crs;

      s6_r    <= s5_r;
      s6_p1_r <= s5_p1_r;
      s6_p2_r <= s5_p2_r;
      s6_p3_r <= s5_p3_r;
      s6_q1_r <= s5_r.mx * s5_a_r;
      s6_q2_r <= s5_r.mz * s5_b_r;

      s7_r    <= s6_r;
      s7_xh_r <= xh;
      s7_yh_r <= yh;

      // turn a negative x by half a turn before the vectoring cells
      s8_r    <= s8_nxt;
      if (s7_xh_r[35]) begin
        s8_x_r <= -CW'(s7_xh_r);
        s8_y_r <= -CW'(s7_yh_r);
        s8_z_r <= 32'h8000_0000;
      end else begin
        s8_x_r <= CW'(s7_xh_r);
        s8_y_r <= CW'(s7_yh_r);
        s8_z_r <= '0;
      end
    end
  end

  // ---------------- vectoring cells
  logic                 cv [0:CSTEPS];
  side_t                cs [0:CSTEPS];
  logic signed [CW-1:0] cx [0:CSTEPS];
  logic signed [CW-1:0] cy [0:CSTEPS];
  logic [31:0]          cz [0:CSTEPS];

  assign cv[0] = s8_v_r;
  assign cs[0] = s8_r;
  assign cx[0] = s8_x_r;
  assign cy[0] = s8_y_r;
  assign cz[0] = s8_z_r;

  for (genvar g = 0; g < CSTEPS; g++) begin : g_cor
    thc_cordic_cell u_cell (
      .clk, .rst_n, .en,
      .i(5'(g)),
      .vld_in(cv[g]), .side_in(cs[g]), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .vld_r(cv[g+1]), .side_r(cs[g+1]), .x_r(cx[g+1]), .y_r(cy[g+1]), .z_r(cz[g+1])
    );
  end

  // ---------------- scale to 1/64 degree and round
  logic        s9_v_r, s9_hz_r, s9_flag_r;
  logic [46:0] s9_prod_r;
  logic [47:0] hsum;
  logic [15:0] hraw;
  logic [14:0] out_heading_r;
  logic        out_flag_r;

  assign hsum = 48'(s9_prod_r) + 48'h0000_8000_0000;
  assign hraw = hsum[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s9_v_r    <= cv[CSTEPS];
      out_valid <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_prod_r  <= 47'(cz[CSTEPS]) * 47'(HEAD_FULL);
      s9_hz_r    <= cs[CSTEPS].hz;
      s9_flag_r  <= cs[CSTEPS].flag;
      out_flag_r <= s9_flag_r;
      // wrap a full turn and drop the angle when there is no horizontal field
      if (s9_hz_r || hraw >= 16'(HEAD_FULL)) begin
        out_heading_r <= '0;
      end else begin
        out_heading_r <= hraw[14:0];
      end
    end
  end

  assign out_heading      = out_heading_r;
  assign out_tilt_clamped = out_flag_r;

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading < HEAD_FULL)
    else $error("heading out of range");

  a_roll_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_r.sr <= 18'sd65536) && (s4_r.sr >= -18'sd65536))
    else $error("roll sine beyond unit");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(s9_prod_r) && $stable(s9_v_r))
    else $error("pipeline moved while result stalled");

endmodule
